FILE: rtl/assert_macros.svh
// assertion macros for the rtl files that check their own logic; used by byte_stream_reassembler
// expects clk_i and rst_ni in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold on every clock edge out of reset
`define BSR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// implication checked on every clock edge out of reset
`define BSR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// implication whose consequence is checked in the cycle after the antecedent
`define BSR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/bsr_pkg.sv
// types and constants of the byte stream reassembler
// no dependencies
`timescale 1ns / 1ps

package bsr_pkg;

  localparam int unsigned IDX_W  = 32;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CNT_W  = 7;
  localparam int unsigned END_W  = 33;

  // end position before any end mark was seen
  localparam logic [END_W-1:0] END_UNKNOWN = '1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_CMP,
    ST_SCAN,
    ST_READ,
    ST_LOAD,
    ST_EMPTY
  } bsr_state_e;

  typedef struct packed {
    logic load_item;
    logic eval;
    logic cmp;
    logic scan_step;
    logic rd_emit;
    logic load_out;
    logic load_empty;
  } bsr_cmd_t;

  typedef struct packed {
    logic hit_filled;
    logic can_drain;
    logic none_drained;
    logic last_emit;
    logic out_free;
  } bsr_status_t;

endpackage

FILE: rtl/bsr_if.sv
// valid/ready channel interfaces of the byte stream reassembler
// depends on bsr_pkg
`timescale 1ns / 1ps

interface bsr_in_if;
  logic                        valid;
  logic                        ready;
  logic [bsr_pkg::IDX_W-1:0]   stream_index;
  logic [bsr_pkg::BYTE_W-1:0]  data_byte;
  logic                        byte_present;
  logic                        eof_flag;
  logic [bsr_pkg::CNT_W-1:0]   out_occupancy;

  modport source (
    output valid, stream_index, data_byte, byte_present, eof_flag, out_occupancy,
    input  ready
  );
  modport sink (
    input  valid, stream_index, data_byte, byte_present, eof_flag, out_occupancy,
    output ready
  );
endinterface

interface bsr_out_if;
  logic                        valid;
  logic                        ready;
  logic [bsr_pkg::BYTE_W-1:0]  out_byte;
  logic                        out_valid;
  logic                        stream_ended;
  logic                        conflict;
  logic [bsr_pkg::CNT_W-1:0]   pending_count;
  logic                        last_result;

  modport source (
    output valid, out_byte, out_valid, stream_ended, conflict, pending_count, last_result,
    input  ready
  );
  modport sink (
    input  valid, out_byte, out_valid, stream_ended, conflict, pending_count, last_result,
    output ready
  );
endinterface

FILE: rtl/byte_stream_reassembler.sv
// sequence: an accepted item is evaluated, the drain scan then clears one valid bit per scan
//   step until a closing scan, and each drained byte is read from the ram and loaded as a
//   result (an empty result if none drained); a byte that hits a filled slot adds a compare step
// items: one at a time; the next item is accepted only after the last result of this one is loaded
// the single read port of the slot ram and the drain scan over the valid bits set the pace
// reset: async active low; valid bits, counters and end position clear, ram is left as is
`timescale 1ns / 1ps

module byte_stream_reassembler #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bsr_in_if.sink      in_i,
  bsr_out_if.source   out_o
);

  bsr_pkg::bsr_cmd_t    cmd;
  bsr_pkg::bsr_status_t status;
  logic                 in_ready;
  logic [5:0]           dp_cmds;
  logic                 dp_load;
  logic                 out_empty;

  bsr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bsr_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .stream_index_i  (in_i.stream_index),
    .data_byte_i     (in_i.data_byte),
    .byte_present_i  (in_i.byte_present),
    .eof_flag_i      (in_i.eof_flag),
    .out_occupancy_i (in_i.out_occupancy),
    .out_ready_i     (out_o.ready),
    .out_vld_o       (out_o.valid),
    .out_byte_o      (out_o.out_byte),
    .out_valid_o     (out_o.out_valid),
    .stream_ended_o  (out_o.stream_ended),
    .conflict_o      (out_o.conflict),
    .pending_count_o (out_o.pending_count),
    .last_result_o   (out_o.last_result)
  );

  assign in_i.ready = in_ready;

  assign dp_cmds   = {cmd.eval, cmd.cmp, cmd.scan_step, cmd.rd_emit, cmd.load_out,
                      cmd.load_empty};
  assign dp_load   = cmd.load_out || cmd.load_empty;
  assign out_empty = out_o.valid && !out_o.out_valid;

`include "assert_macros.svh"

  // only one datapath operation per cycle
  `BSR_ASSERT(a_one_cmd, $onehot0(dp_cmds), "more than one datapath command")
  // a result is only loaded when the output register can take it
  `BSR_ASSERT_IMPL(a_load_free, dp_load, status.out_free, "result register overwritten")
  // an accepted item keeps the block busy in the next cycle
  `BSR_ASSERT_NEXT(a_busy_after_accept, in_i.valid && in_i.ready, !in_i.ready, "no busy cycle")
  // a result without a byte is always the only result of its item
  `BSR_ASSERT_IMPL(a_empty_last, out_empty, out_o.last_result, "empty result not last")

endmodule

FILE: rtl/bsr_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module bsr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic                                        re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/bsr_ctrl.sv
// sequencing state machine of the byte stream reassembler
// depends on bsr_pkg
`timescale 1ns / 1ps

module bsr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  bsr_pkg::bsr_status_t status_i,
  output bsr_pkg::bsr_cmd_t    cmd_o
);

  bsr_pkg::bsr_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bsr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      bsr_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = bsr_pkg::ST_EVAL;
      end
      bsr_pkg::ST_EVAL: begin
        state_d = status_i.hit_filled ? bsr_pkg::ST_CMP : bsr_pkg::ST_SCAN;
      end
      bsr_pkg::ST_CMP: begin
        state_d = bsr_pkg::ST_SCAN;
      end
      bsr_pkg::ST_SCAN: begin
        if (!status_i.can_drain) begin
          state_d = status_i.none_drained ? bsr_pkg::ST_EMPTY : bsr_pkg::ST_READ;
        end
      end
      bsr_pkg::ST_READ: begin
        state_d = bsr_pkg::ST_LOAD;
      end
      bsr_pkg::ST_LOAD: begin
        if (status_i.out_free) begin
          state_d = status_i.last_emit ? bsr_pkg::ST_IDLE : bsr_pkg::ST_READ;
        end
      end
      bsr_pkg::ST_EMPTY: begin
        if (status_i.out_free) state_d = bsr_pkg::ST_IDLE;
      end
      default: state_d = bsr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      bsr_pkg::ST_IDLE: begin
        in_ready_o        = 1'b1;
        cmd_o.load_item   = in_valid_i;
      end
      bsr_pkg::ST_EVAL:  cmd_o.eval       = 1'b1;
      bsr_pkg::ST_CMP:   cmd_o.cmp        = 1'b1;
      bsr_pkg::ST_SCAN:  cmd_o.scan_step  = status_i.can_drain;
      bsr_pkg::ST_READ:  cmd_o.rd_emit    = 1'b1;
      bsr_pkg::ST_LOAD:  cmd_o.load_out   = status_i.out_free;
      bsr_pkg::ST_EMPTY: cmd_o.load_empty = status_i.out_free;
      default: begin
        cmd_o      = '0;
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

FILE: rtl/bsr_dp.sv
// datapath: window check, valid bits, slot ram, stream counters, result register
// depends on bsr_pkg and bsr_ram
`timescale 1ns / 1ps

module bsr_dp #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bsr_pkg::bsr_cmd_t           cmd_i,
  output bsr_pkg::bsr_status_t        status_o,
  input  logic [bsr_pkg::IDX_W-1:0]   stream_index_i,
  input  logic [bsr_pkg::BYTE_W-1:0]  data_byte_i,
  input  logic                        byte_present_i,
  input  logic                        eof_flag_i,
  input  logic [bsr_pkg::CNT_W-1:0]   out_occupancy_i,
  input  logic                        out_ready_i,
  output logic                        out_vld_o,
  output logic [bsr_pkg::BYTE_W-1:0]  out_byte_o,
  output logic                        out_valid_o,
  output logic                        stream_ended_o,
  output logic                        conflict_o,
  output logic [bsr_pkg::CNT_W-1:0]   pending_count_o,
  output logic                        last_result_o
);

  localparam int unsigned PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [PW-1:0]               PTR_LAST = PW'(CAPACITY - 1);
  localparam logic [PW:0]                 CAP_SUM  = (PW + 1)'(CAPACITY);
  localparam logic [bsr_pkg::CNT_W-1:0]   CAP_CNT  = bsr_pkg::CNT_W'(CAPACITY);

  // item registers
  logic [bsr_pkg::IDX_W-1:0]  idx_q;
  logic [bsr_pkg::BYTE_W-1:0] byte_q;
  logic                       present_q;
  logic                       eof_q;
  logic [bsr_pkg::CNT_W-1:0]  occ_q;

  // stream state
  logic [bsr_pkg::IDX_W-1:0]  next_index_q, next_index_d;
  logic [PW-1:0]              rd_ptr_q, rd_ptr_d;
  logic [bsr_pkg::END_W-1:0]  end_q, end_d;
  logic [bsr_pkg::CNT_W-1:0]  stored_q, stored_d;
  logic [CAPACITY-1:0]        valid_q, valid_d;

  // per item bookkeeping
  logic                       conflict_q, conflict_d;
  logic [bsr_pkg::CNT_W-1:0]  drain_n_q, drain_n_d;
  logic [bsr_pkg::IDX_W-1:0]  emit_idx_q, emit_idx_d;
  logic [PW-1:0]              emit_ptr_q, emit_ptr_d;

  // result register
  logic                       ovld_q, ovld_d;
  logic [bsr_pkg::BYTE_W-1:0] obyte_q, obyte_d;
  logic                       obvalid_q, obvalid_d;
  logic                       oended_q, oended_d;
  logic                       oconf_q, oconf_d;
  logic [bsr_pkg::CNT_W-1:0]  opend_q, opend_d;
  logic                       olast_q, olast_d;

  logic [bsr_pkg::IDX_W-1:0]  diff;
  logic [bsr_pkg::CNT_W-1:0]  room;
  logic                       in_win;
  logic [PW:0]                slot_sum;
  logic [PW-1:0]              slot;
  logic                       slot_filled;
  logic                       store;
  logic [bsr_pkg::END_W-1:0]  eof_end;
  logic                       ended;
  logic [bsr_pkg::BYTE_W-1:0] ram_rdata;
  logic [PW-1:0]              ram_raddr;
  logic                       out_free;

  // ring pointer step; the slot jumps to zero when the 32-bit index wraps
  function automatic logic [PW-1:0] ptr_step(input logic [PW-1:0] ptr,
                                             input logic [bsr_pkg::IDX_W-1:0] index);
    logic [PW-1:0] res;
    if (&index) begin
      res = '0;
    end else if (ptr == PTR_LAST) begin
      res = '0;
    end else begin
      res = ptr + PW'(1);
    end
    return res;
  endfunction

  always_comb begin
    diff     = idx_q - next_index_q;
    room     = (occ_q >= CAP_CNT) ? '0 : CAP_CNT - occ_q;
    in_win   = present_q && (idx_q >= next_index_q) && (diff < bsr_pkg::IDX_W'(room));
    // offset is below the capacity inside the window, so one subtract folds it
    slot_sum = {1'b0, rd_ptr_q} + {1'b0, diff[PW-1:0]};
    slot     = (slot_sum >= CAP_SUM) ? PW'(slot_sum - CAP_SUM) : slot_sum[PW-1:0];
    slot_filled = in_win && valid_q[slot];
    store    = in_win && !slot_filled;
    eof_end  = {1'b0, idx_q} + bsr_pkg::END_W'(present_q);
    ended    = ({1'b0, next_index_q} == end_q);
    out_free = !ovld_q || out_ready_i;
  end

  always_comb begin
    status_o.hit_filled   = slot_filled;
    status_o.can_drain    = ({1'b0, next_index_q} < end_q) && valid_q[rd_ptr_q];
    status_o.none_drained = (drain_n_q == '0);
    status_o.last_emit    = (drain_n_q == bsr_pkg::CNT_W'(1));
    status_o.out_free     = out_free;
  end

  assign ram_raddr = cmd_i.rd_emit ? emit_ptr_q : slot;

  bsr_ram #(
    .WIDTH (bsr_pkg::BYTE_W),
    .DEPTH (CAPACITY)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.eval && store),
    .waddr_i (slot),
    .wdata_i (byte_q),
    .re_i    (cmd_i.eval || cmd_i.rd_emit),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      idx_q     <= stream_index_i;
      byte_q    <= data_byte_i;
      present_q <= byte_present_i;
      eof_q     <= eof_flag_i;
      occ_q     <= out_occupancy_i;
    end
  end

  always_comb begin
    next_index_d = next_index_q;
    rd_ptr_d     = rd_ptr_q;
    end_d        = end_q;
    stored_d     = stored_q;
    valid_d      = valid_q;
    conflict_d   = conflict_q;
    drain_n_d    = drain_n_q;
    emit_idx_d   = emit_idx_q;
    emit_ptr_d   = emit_ptr_q;

    if (cmd_i.eval) begin
      if (store) begin
        valid_d[slot] = 1'b1;
        stored_d      = stored_q + bsr_pkg::CNT_W'(1);
      end
      if (eof_q && (eof_end < end_q)) begin
        end_d = eof_end;
      end
      conflict_d = 1'b0;
      drain_n_d  = '0;
      emit_idx_d = next_index_q;
      emit_ptr_d = rd_ptr_q;
    end

    if (cmd_i.cmp) begin
      conflict_d = (ram_rdata != byte_q);
    end

    // commit the drain first, the bytes are replayed from the ram afterwards
    if (cmd_i.scan_step) begin
      valid_d[rd_ptr_q] = 1'b0;
      next_index_d      = next_index_q + bsr_pkg::IDX_W'(1);
      rd_ptr_d          = ptr_step(rd_ptr_q, next_index_q);
      stored_d          = stored_q - bsr_pkg::CNT_W'(1);
      drain_n_d         = drain_n_q + bsr_pkg::CNT_W'(1);
    end

    if (cmd_i.load_out) begin
      emit_idx_d = emit_idx_q + bsr_pkg::IDX_W'(1);
      emit_ptr_d = ptr_step(emit_ptr_q, emit_idx_q);
      drain_n_d  = drain_n_q - bsr_pkg::CNT_W'(1);
    end
  end

  always_comb begin
    ovld_d    = ovld_q;
    obyte_d   = obyte_q;
    obvalid_d = obvalid_q;
    oended_d  = oended_q;
    oconf_d   = oconf_q;
    opend_d   = opend_q;
    olast_d   = olast_q;
    if (cmd_i.load_out || cmd_i.load_empty) begin
      ovld_d    = 1'b1;
      obyte_d   = cmd_i.load_out ? ram_rdata : '0;
      obvalid_d = cmd_i.load_out;
      oended_d  = ended;
      oconf_d   = conflict_q;
      opend_d   = stored_q;
      olast_d   = cmd_i.load_empty || status_o.last_emit;
    end else if (out_ready_i) begin
      ovld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_index_q <= '0;
      rd_ptr_q     <= '0;
      end_q        <= bsr_pkg::END_UNKNOWN;
      stored_q     <= '0;
      valid_q      <= '0;
      conflict_q   <= 1'b0;
      drain_n_q    <= '0;
      emit_idx_q   <= '0;
      emit_ptr_q   <= '0;
      ovld_q       <= 1'b0;
    end else begin
      next_index_q <= next_index_d;
      rd_ptr_q     <= rd_ptr_d;
      end_q        <= end_d;
      stored_q     <= stored_d;
      valid_q      <= valid_d;
      conflict_q   <= conflict_d;
      drain_n_q    <= drain_n_d;
      emit_idx_q   <= emit_idx_d;
      emit_ptr_q   <= emit_ptr_d;
      ovld_q       <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    obyte_q   <= obyte_d;
    obvalid_q <= obvalid_d;
    oended_q  <= oended_d;
    oconf_q   <= oconf_d;
    opend_q   <= opend_d;
    olast_q   <= olast_d;
  end

  assign out_vld_o       = ovld_q;
  assign out_byte_o      = obyte_q;
  assign out_valid_o     = obvalid_q;
  assign stream_ended_o  = oended_q;
  assign conflict_o      = oconf_q;
  assign pending_count_o = opend_q;
  assign last_result_o   = olast_q;

endmodule
